### rtl/bds_pkg.sv
`default_nettype none
package bds_pkg;

  // Widest source row the line store can hold
  localparam int MAX_WIDTH  = 4096;
  localparam int PAIR_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W     = $clog2(PAIR_DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH);

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int FW_W     = 13;
  localparam int FH_W     = 16;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 2;
  localparam int AVG_W    = 8;
  localparam int PSUM_W   = 9;
  localparam int ENTRY_W  = PSUM_W + 1;

  localparam logic [SAMPLE_W-1:0] CLIP16_LIMIT = 16'd65528;
  localparam logic [7:0]          CLIP8_VALUE  = 8'd255;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 13'd4096;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 16'd4096;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_WIDE_SAMPLES = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  // One result word
  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic             clipped;
    logic             row_end;
    logic             frame_end;
  } result_t;

endpackage
`default_nettype wire

### rtl/box_downsample_2x2_clip_core.sv
`default_nettype none
// Channel   Handshake             Payload
// input     in_valid / in_ready   sample
// output    out_valid / out_ready average, clipped, row_end, frame_end
// config    cfg_write             cfg_index, cfg_data
//
// One sample per clock while in_ready is high. A result leaves the line store read
// in the cycle after its last sample is taken and lands in a two-word output queue.
// in_ready drops only while the queue plus the word in flight fill two or more slots,
// so with out_ready high the block takes a sample every cycle.
// Reset clears counters, registers and the queue; the line store is not
// cleared and each entry is read only after the even row wrote it.
module box_downsample_2x2_clip_core
  import bds_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [AVG_W-1:0]         average,
  output logic                     clipped,
  output logic                     row_end,
  output logic                     frame_end,
  input  wire logic                cfg_write,
  input  wire logic [IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data
);

  logic            wide_samples;
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;

  logic [COL_W-1:0] column_count;
  logic [FH_W-1:0]  row_count;
  logic [PSUM_W-1:0] left_partial;

  logic [FW_W-1:0] w_eff;
  logic [FW_W-1:0] we_eff;
  logic [FH_W-1:0] h_eff;
  logic [FH_W-1:0] he_eff;

  logic            accept;
  logic            in_frame;
  logic [7:0]      red;
  logic            clip;
  logic [PSUM_W-1:0] psum;
  logic            pclip;
  logic            is_pair;
  logic            pair_write;
  logic            pair_read;
  logic            rend;
  logic            fend;
  logic [ENTRY_W-1:0] ram_rdata;

  // word in flight, waiting on the line store read
  logic            s1_valid;
  logic [PSUM_W-1:0] s1_psum;
  logic            s1_clip;
  logic            s1_rend;
  logic            s1_fend;
  logic [PSUM_W:0] s1_sum;
  result_t         s1_res;

  // output queue
  logic    head_valid;
  logic    skid_valid;
  result_t head;
  result_t skid;
  logic    pop;
  logic [1:0] occupancy;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      wide_samples <= 1'b0;
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDE_SAMPLES: wide_samples <= cfg_data[0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width < FW_W'(2)) begin
      w_eff = FW_W'(2);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = FW_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    we_eff = {w_eff[FW_W-1:1], 1'b0};
    h_eff  = (frame_height < FH_W'(2)) ? FH_W'(2) : frame_height;
    he_eff = {h_eff[FH_W-1:1], 1'b0};
  end

  assign occupancy = 2'(head_valid) + 2'(skid_valid) + 2'(s1_valid);
  assign in_ready  = occupancy < 2'd2;
  assign accept    = in_valid && in_ready;

  always_comb begin
    in_frame = (32'(column_count) < 32'(we_eff)) && (row_count < he_eff);
    if (wide_samples) begin
      red  = sample[15:8];
      clip = sample >= CLIP16_LIMIT;
    end else begin
      red  = sample[7:0];
      clip = sample[7:0] == CLIP8_VALUE;
    end
    psum       = PSUM_W'(left_partial[7:0]) + PSUM_W'(red);
    pclip      = left_partial[8] | clip;
    is_pair    = accept && in_frame && column_count[0];
    pair_write = is_pair && !row_count[0];
    pair_read  = is_pair && row_count[0];
    rend       = 32'(column_count) == 32'(we_eff) - 32'd1;
    fend       = rend && (row_count == he_eff - FH_W'(1));
  end

  // counters and pending left pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      left_partial <= '0;
    end else if (accept) begin
      if (in_frame && !column_count[0]) begin
        left_partial <= {clip, red};
      end
      if (32'(column_count) >= 32'(w_eff) - 32'd1) begin
        column_count <= '0;
        row_count    <= (row_count >= h_eff - FH_W'(1)) ? '0 : row_count + FH_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  bds_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(PAIR_DEPTH)
  ) u_pair_line (
    .clk  (clk),
    .en   (is_pair),
    .we   (pair_write),
    .addr (column_count[COL_W-1:1]),
    .wdata({pclip, psum}),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= pair_read;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_read) begin
      s1_psum <= psum;
      s1_clip <= pclip;
      s1_rend <= rend;
      s1_fend <= fend;
    end
  end

  always_comb begin
    s1_sum           = (PSUM_W + 1)'(ram_rdata[PSUM_W-1:0]) + (PSUM_W + 1)'(s1_psum);
    s1_res.average   = s1_sum[PSUM_W:2];
    s1_res.clipped   = ram_rdata[PSUM_W] | s1_clip;
    s1_res.row_end   = s1_rend;
    s1_res.frame_end = s1_fend;
  end

  assign pop = head_valid && out_ready;

  // two-word queue: head drives the port, skid catches a word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      head_valid <= skid_valid || s1_valid;
      skid_valid <= skid_valid && s1_valid;
    end else if (s1_valid && head_valid) begin
      skid_valid <= 1'b1;
    end else if (s1_valid) begin
      head_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        head <= skid;
        if (s1_valid) begin
          skid <= s1_res;
        end
      end else if (s1_valid) begin
        head <= s1_res;
      end
    end else if (s1_valid) begin
      if (head_valid) begin
        skid <= s1_res;
      end else begin
        head <= s1_res;
      end
    end
  end

  assign out_valid = head_valid;
  assign average   = head.average;
  assign clipped   = head.clipped;
  assign row_end   = head.row_end;
  assign frame_end = head.frame_end;

endmodule
`default_nettype wire

### rtl/bds_ram.sv
`default_nettype none
module bds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire
